[rtl/core/hset_pkg.sv]
// hset_pkg: shared widths, codes and types for the chained hash set engine
package hset_pkg;

	localparam int REQ_W = 2;
	localparam int ID_W  = 13;
	localparam int BKT_W = 12;
	localparam int CNT_W = 14;

	localparam int ELEMENTS_DEF = 8192;
	localparam int BUCKETS_DEF  = 4096;

	// request queue between front and back, power of two
	localparam int QDEPTH = 2;

	localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};

	localparam logic [REQ_W-1:0] REQ_INSERT = 2'd0;
	localparam logic [REQ_W-1:0] REQ_DELETE = 2'd1;
	localparam logic [REQ_W-1:0] REQ_FIND   = 2'd2;

	typedef enum logic [1:0] {
		OP_INSERT = 2'd0,
		OP_DELETE = 2'd1,
		OP_FIND   = 2'd2
	} op_t;

	typedef struct packed {
		op_t              op;
		logic [ID_W-1:0]  element_id;
		logic [BKT_W-1:0] bucket;
		logic             ignore;
	} item_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

endpackage

[rtl/core/hset_front.sv]
// hset_front: accepts request words, decodes them and range-checks id and bucket
module hset_front #(
	parameter int ELEMENTS = hset_pkg::ELEMENTS_DEF,
	parameter int BUCKETS  = hset_pkg::BUCKETS_DEF
) (
	input  logic                        start,
	output logic                        busy,
	input  logic [hset_pkg::REQ_W-1:0]  req_type,
	input  logic [hset_pkg::ID_W-1:0]   element_id,
	input  logic [hset_pkg::BKT_W-1:0]  bucket,
	input  hset_pkg::q_stat_t           q_stat,
	input  logic                        clearing,
	output logic                        push,
	output hset_pkg::item_t             item
);

	logic id_ok;
	logic bkt_ok;

	assign busy = q_stat.full || clearing;
	assign push = start && !busy;

	assign id_ok  = 32'(element_id) < 32'(ELEMENTS);
	assign bkt_ok = 32'(bucket) < 32'(BUCKETS);

	always_comb begin
		item.element_id = element_id;
		item.bucket     = bucket;
		item.ignore     = !(id_ok && bkt_ok);
		case (req_type)
			hset_pkg::REQ_INSERT: begin
				item.op = hset_pkg::OP_INSERT;
			end
			hset_pkg::REQ_DELETE: begin
				item.op = hset_pkg::OP_DELETE;
			end
			hset_pkg::REQ_FIND: begin
				item.op = hset_pkg::OP_FIND;
			end
			default: begin
				// spare code behaves as a find
				item.op = hset_pkg::OP_FIND;
			end
		endcase
	end

endmodule

[rtl/core/hset_queue.sv]
// hset_queue: short fifo of classified request words between front and back
module hset_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  hset_pkg::item_t   push_item,
	input  logic              pop,
	output hset_pkg::item_t   head_item,
	output hset_pkg::q_stat_t q_stat
);

	localparam int PW = $clog2(hset_pkg::QDEPTH);
	localparam int CW = $clog2(hset_pkg::QDEPTH + 1);

	hset_pkg::item_t mem_q [hset_pkg::QDEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [CW-1:0]   cnt_q;

	assign head_item    = mem_q[rd_ptr_q];
	assign q_stat.full  = cnt_q == CW'(hset_pkg::QDEPTH);
	assign q_stat.empty = cnt_q == '0;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

[rtl/core/hset_back.sv]
// hset_back: chain walker with bucket head and link memories, element count and result
module hset_back #(
	parameter int ELEMENTS = hset_pkg::ELEMENTS_DEF,
	parameter int BUCKETS  = hset_pkg::BUCKETS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  hset_pkg::item_t             q_item,
	input  hset_pkg::q_stat_t           q_stat,
	output logic                        pop,
	output logic                        clearing,
	output logic                        done,
	output logic                        found,
	output logic [hset_pkg::CNT_W-1:0]  element_count
);

	localparam int LW = $clog2(ELEMENTS + 1);
	localparam int IW = $clog2(ELEMENTS);
	localparam int BW = $clog2(BUCKETS);
	localparam logic [LW-1:0] NULL_LINK = LW'(ELEMENTS);
	localparam logic [BW-1:0] LAST_BKT  = BW'(BUCKETS - 1);

	typedef enum logic [5:0] {
		S_CLEAR = 6'b000001,
		S_IDLE  = 6'b000010,
		S_HEAD  = 6'b000100,
		S_STEP  = 6'b001000,
		S_DNXT  = 6'b010000,
		S_DCLR  = 6'b100000
	} state_t;

	state_t                     state_q;
	state_t                     state_d;
	logic [BW-1:0]              clr_q;
	hset_pkg::item_t            item_q;
	logic [LW-1:0]              head_q;
	logic [LW-1:0]              before_q;
	logic [LW-1:0]              steps_q;
	logic [hset_pkg::CNT_W-1:0] count_q;
	logic                       done_q;
	logic                       found_q;

	logic [LW-1:0] heads_mem [BUCKETS];
	logic [LW-1:0] links_mem [ELEMENTS];
	logic [LW-1:0] head_rd_q;
	logic [LW-1:0] link_rd_q;

	logic          hd_we;
	logic [BW-1:0] hd_waddr;
	logic [LW-1:0] hd_wdata;
	logic          hd_re;
	logic [BW-1:0] hd_raddr;
	logic          lk_we;
	logic [IW-1:0] lk_waddr;
	logic [LW-1:0] lk_wdata;
	logic          lk_re;
	logic [IW-1:0] lk_raddr;

	logic          latch_item;
	logic          walk_adv;
	logic          fin;
	logic          fin_found;
	logic          cnt_inc;
	logic          cnt_dec;
	logic [LW-1:0] cur_w;
	logic [LW-1:0] head_val;
	logic [LW-1:0] id_link;
	logic [BW-1:0] bkt_idx;
	logic          at_end;
	logic          hit;

	assign clearing      = state_q == S_CLEAR;
	assign done          = done_q;
	assign found         = found_q;
	assign element_count = count_q;

	assign id_link  = LW'(item_q.element_id);
	assign bkt_idx  = BW'(item_q.bucket);
	// the link under test comes from whichever memory was read last cycle
	assign cur_w    = (state_q == S_HEAD) ? head_rd_q : link_rd_q;
	assign head_val = (state_q == S_HEAD) ? head_rd_q : head_q;
	assign at_end   = (cur_w >= NULL_LINK) || (steps_q == NULL_LINK);
	assign hit      = cur_w == id_link;

	always_comb begin
		state_d    = state_q;
		pop        = 1'b0;
		hd_we      = 1'b0;
		hd_waddr   = bkt_idx;
		hd_wdata   = NULL_LINK;
		hd_re      = 1'b0;
		hd_raddr   = BW'(q_item.bucket);
		lk_we      = 1'b0;
		lk_waddr   = IW'(item_q.element_id);
		lk_wdata   = NULL_LINK;
		lk_re      = 1'b0;
		lk_raddr   = IW'(item_q.element_id);
		latch_item = 1'b0;
		walk_adv   = 1'b0;
		fin        = 1'b0;
		fin_found  = 1'b0;
		cnt_inc    = 1'b0;
		cnt_dec    = 1'b0;
		case (state_q)
			S_CLEAR: begin
				hd_we    = 1'b1;
				hd_waddr = clr_q;
				hd_wdata = NULL_LINK;
				if (clr_q == LAST_BKT) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (!q_stat.empty) begin
					pop        = 1'b1;
					latch_item = 1'b1;
					if (q_item.ignore) begin
						fin = 1'b1;
					end else begin
						hd_re   = 1'b1;
						state_d = S_HEAD;
					end
				end
			end
			S_HEAD, S_STEP: begin
				if (at_end) begin
					fin     = 1'b1;
					state_d = S_IDLE;
					if (item_q.op == hset_pkg::OP_INSERT) begin
						// prepend: new id points at the old head
						lk_we    = 1'b1;
						lk_wdata = head_val;
						hd_we    = 1'b1;
						hd_wdata = id_link;
						cnt_inc  = 1'b1;
					end
				end else if (hit) begin
					if (item_q.op == hset_pkg::OP_DELETE) begin
						lk_re   = 1'b1;
						state_d = S_DNXT;
					end else begin
						fin       = 1'b1;
						fin_found = 1'b1;
						state_d   = S_IDLE;
					end
				end else begin
					lk_re    = 1'b1;
					lk_raddr = IW'(cur_w);
					walk_adv = 1'b1;
					state_d  = S_STEP;
				end
			end
			S_DNXT: begin
				// bypass the found id: predecessor link or bucket head takes its successor
				if (before_q < NULL_LINK) begin
					lk_we    = 1'b1;
					lk_waddr = IW'(before_q);
					lk_wdata = link_rd_q;
				end else begin
					hd_we    = 1'b1;
					hd_wdata = link_rd_q;
				end
				state_d = S_DCLR;
			end
			S_DCLR: begin
				lk_we     = 1'b1;
				lk_wdata  = NULL_LINK;
				fin       = 1'b1;
				fin_found = 1'b1;
				cnt_dec   = 1'b1;
				state_d   = S_IDLE;
			end
			default: begin
				state_d = S_CLEAR;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (hd_we) begin
			heads_mem[hd_waddr] <= hd_wdata;
		end
		if (hd_re) begin
			head_rd_q <= heads_mem[hd_raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (lk_we) begin
			links_mem[lk_waddr] <= lk_wdata;
		end
		if (lk_re) begin
			link_rd_q <= links_mem[lk_raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (latch_item) begin
			item_q   <= q_item;
			before_q <= NULL_LINK;
			steps_q  <= '0;
		end else if (walk_adv) begin
			before_q <= cur_w;
			steps_q  <= steps_q + 1'b1;
		end
		if (state_q == S_HEAD) begin
			head_q <= head_rd_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clr_q   <= '0;
			count_q <= '0;
			done_q  <= 1'b0;
			found_q <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= fin;
			if (state_q == S_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end
			if (fin) begin
				found_q <= fin_found;
			end
			if (cnt_inc && count_q != hset_pkg::COUNT_MAX) begin
				count_q <= count_q + 1'b1;
			end else if (cnt_dec && count_q != '0) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	a_no_result_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_CLEAR |-> !done_q)
		else $error("result strobe during head clearing");

	a_count_moves_with_result: assert property (@(posedge clk) disable iff (!arst_n)
		count_q != $past(count_q) |-> done_q)
		else $error("element count changed without a result");

	a_delete_reports_found: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DCLR |=> done_q && found_q)
		else $error("unlink did not end in a found result");

	a_walk_only_valid: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_STEP |-> !item_q.ignore && steps_q != '0)
		else $error("chain walk on an ignored word or without a step");

endmodule

[rtl/core/chained_hash_set_engine_top.sv]
// chained_hash_set_engine_top: hash set of element ids with per-bucket linked chains
// result: an ignored word (id or bucket out of range) gives done without a chain walk;
//   otherwise the bucket head is read and its chain walked; a delete that unlinks adds S_DNXT, S_DCLR
// throughput: one chain link per cycle through the single link memory read port;
//   a 2-word queue lets start be taken while the walker is busy
// reset: all bucket heads are swept to empty while busy is held high
module chained_hash_set_engine_top #(
	parameter int ELEMENTS = hset_pkg::ELEMENTS_DEF,
	parameter int BUCKETS  = hset_pkg::BUCKETS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic [hset_pkg::REQ_W-1:0]  req_type,
	input  logic [hset_pkg::ID_W-1:0]   element_id,
	input  logic [hset_pkg::BKT_W-1:0]  bucket,
	output logic                        done,
	output logic                        found,
	output logic [hset_pkg::CNT_W-1:0]  element_count
);

	hset_pkg::item_t   push_item;
	hset_pkg::item_t   head_item;
	hset_pkg::q_stat_t q_stat;
	logic              push;
	logic              pop;
	logic              clearing;

	hset_front #(
		.ELEMENTS (ELEMENTS),
		.BUCKETS  (BUCKETS)
	) u_front (
		.start      (start),
		.busy       (busy),
		.req_type   (req_type),
		.element_id (element_id),
		.bucket     (bucket),
		.q_stat     (q_stat),
		.clearing   (clearing),
		.push       (push),
		.item       (push_item)
	);

	hset_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (pop),
		.head_item (head_item),
		.q_stat    (q_stat)
	);

	hset_back #(
		.ELEMENTS (ELEMENTS),
		.BUCKETS  (BUCKETS)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_item        (head_item),
		.q_stat        (q_stat),
		.pop           (pop),
		.clearing      (clearing),
		.done          (done),
		.found         (found),
		.element_count (element_count)
	);

endmodule
